// ----- hw/rtl/assert_macros.svh -----
// assertion helpers shared by the rtl modules
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define DTPB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dtpb assertion failed");

// next-cycle implication, held off during reset
`define DTPB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dtpb assertion failed");

`endif

// ----- hw/rtl/dtpb_pkg.sv -----
// shared types, widths and constants for the depth back-projection unit
// no dependencies
package dtpb_pkg;

    localparam int WIDTH_BITS     = 13;
    localparam int CENTRE_BITS    = 12;
    localparam int FOCAL_BITS     = 32;
    localparam int DEPTH_BITS     = 16;
    localparam int COLOUR_BITS    = 8;
    localparam int POINT_BITS     = 32;
    localparam int FRAC_SHIFT     = 24;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 32;
    localparam int COORD_BITS_DEF = 12;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [WIDTH_BITS-1:0]  IMAGE_WIDTH_RST = 13'd640;
    localparam logic [CENTRE_BITS-1:0] CENTER_COL_RST  = 12'd320;
    localparam logic [CENTRE_BITS-1:0] CENTER_ROW_RST  = 12'd240;
    localparam logic [FOCAL_BITS-1:0]  INV_FOCAL_RST   = 32'd7531001;

    localparam logic [POINT_BITS-1:0] POS_LIMIT = 32'h7FFF_FFFF;
    localparam logic [POINT_BITS-1:0] NEG_LIMIT = 32'h8000_0000;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_IMAGE_WIDTH = 2'd0,
        CFG_CENTER_COL  = 2'd1,
        CFG_CENTER_ROW  = 2'd2,
        CFG_INV_FOCAL   = 2'd3
    } t_cfg_index;

    // magnitude of position minus centre needs the wider of the two
    function automatic int mag_bits(input int coord_bits);
        return (coord_bits > CENTRE_BITS) ? coord_bits : CENTRE_BITS;
    endfunction

    // queue entry: {neg_x, mag_x, neg_y, mag_y, depth, red, green, blue}
    function automatic int entry_bits(input int coord_bits);
        return 2 * (mag_bits(coord_bits) + 1) + DEPTH_BITS + 3 * COLOUR_BITS;
    endfunction

endpackage

// ----- hw/rtl/dtpb_front.sv -----
// front end: accepts pixels, tracks column and row, forms offsets from centre
// depends on dtpb_pkg and assert_macros.svh
`include "assert_macros.svh"

module dtpb_front
    import dtpb_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_full,
    input  logic [DEPTH_BITS-1:0]      i_depth_mm,
    input  logic [COLOUR_BITS-1:0]     i_red_in,
    input  logic [COLOUR_BITS-1:0]     i_green_in,
    input  logic [COLOUR_BITS-1:0]     i_blue_in,
    input  logic                       i_frame_start,
    input  logic [WIDTH_BITS-1:0]      i_image_width,
    input  logic [CENTRE_BITS-1:0]     i_center_col,
    input  logic [CENTRE_BITS-1:0]     i_center_row,
    output logic                       o_push,
    output logic [entry_bits(COORD_BITS)-1:0] o_entry
);

    localparam int MAG_BITS = mag_bits(COORD_BITS);
    localparam int DIF_BITS = MAG_BITS + 1;
    localparam int CMP_BITS = ((COORD_BITS + 1) > WIDTH_BITS) ? (COORD_BITS + 1) : WIDTH_BITS;

    logic [COORD_BITS-1:0] r_col, n_col;
    logic [COORD_BITS-1:0] r_row, n_row;
    logic [COORD_BITS-1:0] w_col, w_row;
    logic [CMP_BITS-1:0]   w_col_inc;
    logic                  w_accept;
    logic                  w_neg_x, w_neg_y, w_zero;
    logic [DIF_BITS-1:0]   w_pos_x, w_pos_y, w_ctr_x, w_ctr_y;
    logic [MAG_BITS-1:0]   w_mag_x, w_mag_y;
    logic [COLOUR_BITS-1:0] w_red, w_green, w_blue;

    assign w_accept = i_in_valid && !i_full;

    // frame start puts this pixel at the origin
    assign w_col = i_frame_start ? '0 : r_col;
    assign w_row = i_frame_start ? '0 : r_row;

    always_comb begin
        w_col_inc = CMP_BITS'(w_col) + CMP_BITS'(1);
        if (w_col_inc >= CMP_BITS'(i_image_width)) begin
            n_col = '0;
            n_row = w_row + COORD_BITS'(1);
        end else begin
            n_col = w_col_inc[COORD_BITS-1:0];
            n_row = w_row;
        end
    end

    always_comb begin
        w_pos_x = DIF_BITS'(w_col);
        w_pos_y = DIF_BITS'(w_row);
        w_ctr_x = DIF_BITS'(i_center_col);
        w_ctr_y = DIF_BITS'(i_center_row);
        w_neg_x = w_pos_x < w_ctr_x;
        w_neg_y = w_pos_y < w_ctr_y;
        w_mag_x = w_neg_x ? MAG_BITS'(w_ctr_x - w_pos_x) : MAG_BITS'(w_pos_x - w_ctr_x);
        w_mag_y = w_neg_y ? MAG_BITS'(w_ctr_y - w_pos_y) : MAG_BITS'(w_pos_y - w_ctr_y);
        // zero depth gives zero products already, only the colour needs clearing
        w_zero  = (i_depth_mm == '0);
        w_red   = w_zero ? '0 : i_red_in;
        w_green = w_zero ? '0 : i_green_in;
        w_blue  = w_zero ? '0 : i_blue_in;
    end

    assign o_push  = w_accept;
    assign o_entry = {w_neg_x, w_mag_x, w_neg_y, w_mag_y, i_depth_mm, w_red, w_green, w_blue};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    `DTPB_ASSERT_NEXT(a_frame_origin, i_clk, i_rst_n, w_accept && i_frame_start && (i_image_width > WIDTH_BITS'(1)), (r_col == COORD_BITS'(1)) && (r_row == '0))

endmodule

// ----- hw/rtl/dtpb_queue.sv -----
// short queue between the front end and the arithmetic back end
// depends on dtpb_pkg and assert_macros.svh
`include "assert_macros.svh"

module dtpb_queue
    import dtpb_pkg::*;
#(
    parameter int DATA_BITS = entry_bits(COORD_BITS_DEF),
    parameter int DEPTH     = QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [DATA_BITS-1:0] i_data,
    output logic                 o_full,
    output logic                 o_valid,
    output logic [DATA_BITS-1:0] o_data,
    input  logic                 i_pop
);

    localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_BITS = $clog2(DEPTH + 1);

    logic [DATA_BITS-1:0]  r_slot [DEPTH];
    logic [PTR_BITS-1:0]   r_wr_ptr, r_rd_ptr, n_wr_ptr, n_rd_ptr;
    logic [COUNT_BITS-1:0] r_count;
    logic                  w_push, w_pop;

    assign o_full  = (r_count == COUNT_BITS'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_slot[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = (r_wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_BITS'(1);
        n_rd_ptr = (r_rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_BITS'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + COUNT_BITS'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - COUNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    `DTPB_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, w_push && !w_pop, r_count == ($past(r_count) + COUNT_BITS'(1)))

endmodule

// ----- hw/rtl/dtpb_back.sv -----
// back end: two multiply stages, then rounding and saturation into the output register
// depends on dtpb_pkg and assert_macros.svh
`include "assert_macros.svh"

module dtpb_back
    import dtpb_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_valid,
    input  logic [entry_bits(COORD_BITS)-1:0] i_q_data,
    output logic                         o_q_pop,
    input  logic [FOCAL_BITS-1:0]        i_inv_focal,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [POINT_BITS-1:0] o_point_x,
    output logic signed [POINT_BITS-1:0] o_point_y,
    output logic [DEPTH_BITS-1:0]        o_point_z,
    output logic [COLOUR_BITS-1:0]       o_red_out,
    output logic [COLOUR_BITS-1:0]       o_green_out,
    output logic [COLOUR_BITS-1:0]       o_blue_out
);

    localparam int MAG_BITS = mag_bits(COORD_BITS);
    localparam int P1_BITS  = MAG_BITS + DEPTH_BITS;
    localparam int P2_BITS  = P1_BITS + FOCAL_BITS;
    localparam int Q_BITS   = P2_BITS - FRAC_SHIFT + 1;
    localparam int RGB_BITS = 3 * COLOUR_BITS;

    // round half away from zero on the magnitude, then sign and clamp
    function automatic logic [POINT_BITS-1:0] round_sat(input logic [P2_BITS-1:0] full,
                                                        input logic neg);
        logic [Q_BITS-1:0]     q;
        logic [POINT_BITS-1:0] res;
        q = Q_BITS'(full >> FRAC_SHIFT) + Q_BITS'(full[FRAC_SHIFT-1]);
        if (neg) begin
            if (q >= Q_BITS'(NEG_LIMIT)) begin
                res = NEG_LIMIT;
            end else begin
                res = POINT_BITS'(0) - q[POINT_BITS-1:0];
            end
        end else begin
            if (q > Q_BITS'(POS_LIMIT)) begin
                res = POS_LIMIT;
            end else begin
                res = q[POINT_BITS-1:0];
            end
        end
        return res;
    endfunction

    logic                  w_neg_x, w_neg_y;
    logic [MAG_BITS-1:0]   w_mag_x, w_mag_y;
    logic [DEPTH_BITS-1:0] w_depth;
    logic [RGB_BITS-1:0]   w_rgb;
    logic [P1_BITS-1:0]    n_p1_x, n_p1_y;
    logic [P2_BITS-1:0]    n_full_x, n_full_y;
    logic [POINT_BITS-1:0] n_out_x, n_out_y;
    logic                  w_adv1, w_adv2, w_adv3;

    // stage 1: offset times depth
    logic                  r_v1;
    logic                  r1_neg_x, r1_neg_y;
    logic [P1_BITS-1:0]    r_p1_x, r_p1_y;
    logic [DEPTH_BITS-1:0] r1_depth;
    logic [RGB_BITS-1:0]   r1_rgb;
    // stage 2: times inverse focal length
    logic                  r_v2;
    logic                  r2_neg_x, r2_neg_y;
    logic [P2_BITS-1:0]    r_full_x, r_full_y;
    logic [DEPTH_BITS-1:0] r2_depth;
    logic [RGB_BITS-1:0]   r2_rgb;
    // stage 3: output register
    logic                  r_v3;
    logic [POINT_BITS-1:0] r_out_x, r_out_y;
    logic [DEPTH_BITS-1:0] r3_depth;
    logic [RGB_BITS-1:0]   r3_rgb;

    assign {w_neg_x, w_mag_x, w_neg_y, w_mag_y, w_depth, w_rgb} = i_q_data;

    // each stage moves when the one after it is empty or moving
    assign w_adv3  = !r_v3 || !i_out_stall;
    assign w_adv2  = !r_v2 || w_adv3;
    assign w_adv1  = !r_v1 || w_adv2;
    assign o_q_pop = i_q_valid && w_adv1;

    assign n_p1_x   = w_mag_x * w_depth;
    assign n_p1_y   = w_mag_y * w_depth;
    assign n_full_x = r_p1_x * i_inv_focal;
    assign n_full_y = r_p1_y * i_inv_focal;
    assign n_out_x  = round_sat(r_full_x, r2_neg_x);
    assign n_out_y  = round_sat(r_full_y, r2_neg_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_adv1) begin
                r_v1 <= i_q_valid;
            end
            if (w_adv2) begin
                r_v2 <= r_v1;
            end
            if (w_adv3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r1_neg_x <= w_neg_x;
            r1_neg_y <= w_neg_y;
            r_p1_x   <= n_p1_x;
            r_p1_y   <= n_p1_y;
            r1_depth <= w_depth;
            r1_rgb   <= w_rgb;
        end
        if (w_adv2) begin
            r2_neg_x <= r1_neg_x;
            r2_neg_y <= r1_neg_y;
            r_full_x <= n_full_x;
            r_full_y <= n_full_y;
            r2_depth <= r1_depth;
            r2_rgb   <= r1_rgb;
        end
        if (w_adv3) begin
            r_out_x  <= n_out_x;
            r_out_y  <= n_out_y;
            r3_depth <= r2_depth;
            r3_rgb   <= r2_rgb;
        end
    end

    assign o_out_valid = r_v3;
    assign o_point_x   = r_out_x;
    assign o_point_y   = r_out_y;
    assign o_point_z   = r3_depth;
    assign {o_red_out, o_green_out, o_blue_out} = r3_rgb;

    `DTPB_ASSERT_NEXT(a_pop_lands, i_clk, i_rst_n, o_q_pop, r_v1)
    `DTPB_ASSERT_NEXT(a_hold_stage2, i_clk, i_rst_n, r_v3 && i_out_stall && r_v2, r_v2 && $stable(r_full_x) && $stable(r_full_y))

endmodule

// ----- hw/rtl/depth_to_point_backprojection_unit.sv -----
//  channel   | valid        | stall        | beat
//  ----------+--------------+--------------+------------------------------------------
//  pixel in  | i_in_valid   | o_in_stall   | depth_mm, red/green/blue_in, frame_start
//  point out | o_out_valid  | i_out_stall  | point_x/y/z, red/green/blue_out
//  config    | i_cfg_we     | -            | i_cfg_index, i_cfg_data
//
// one pixel a cycle sustained while i_out_stall is low, as the back end multiplies in two pipelined stages
// a taken pixel passes through the queue, stage 1, stage 2 and the output register before it shows
// a four-beat queue lets the front keep taking pixels while the output is stalled
// synchronous active-low reset clears position, queue and pipeline and loads default config
// depends on dtpb_pkg, dtpb_front, dtpb_queue, dtpb_back
module depth_to_point_backprojection_unit
    import dtpb_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [DEPTH_BITS-1:0]        i_depth_mm,
    input  logic [COLOUR_BITS-1:0]       i_red_in,
    input  logic [COLOUR_BITS-1:0]       i_green_in,
    input  logic [COLOUR_BITS-1:0]       i_blue_in,
    input  logic                         i_frame_start,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [POINT_BITS-1:0] o_point_x,
    output logic signed [POINT_BITS-1:0] o_point_y,
    output logic [DEPTH_BITS-1:0]        o_point_z,
    output logic [COLOUR_BITS-1:0]       o_red_out,
    output logic [COLOUR_BITS-1:0]       o_green_out,
    output logic [COLOUR_BITS-1:0]       o_blue_out,
    input  logic                         i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]    i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]     i_cfg_data
);

    localparam int ENTRY_BITS = entry_bits(COORD_BITS);

    logic [WIDTH_BITS-1:0]  r_image_width;
    logic [CENTRE_BITS-1:0] r_center_col;
    logic [CENTRE_BITS-1:0] r_center_row;
    logic [FOCAL_BITS-1:0]  r_inv_focal;

    logic                  w_push, w_full, w_q_valid, w_q_pop;
    logic [ENTRY_BITS-1:0] w_push_data, w_q_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width <= IMAGE_WIDTH_RST;
            r_center_col  <= CENTER_COL_RST;
            r_center_row  <= CENTER_ROW_RST;
            r_inv_focal   <= INV_FOCAL_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_IMAGE_WIDTH: begin
                    r_image_width <= i_cfg_data[WIDTH_BITS-1:0];
                end
                CFG_CENTER_COL: begin
                    r_center_col <= i_cfg_data[CENTRE_BITS-1:0];
                end
                CFG_CENTER_ROW: begin
                    r_center_row <= i_cfg_data[CENTRE_BITS-1:0];
                end
                CFG_INV_FOCAL: begin
                    r_inv_focal <= i_cfg_data[FOCAL_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_in_stall = w_full;

    dtpb_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_full        (w_full),
        .i_depth_mm    (i_depth_mm),
        .i_red_in      (i_red_in),
        .i_green_in    (i_green_in),
        .i_blue_in     (i_blue_in),
        .i_frame_start (i_frame_start),
        .i_image_width (r_image_width),
        .i_center_col  (r_center_col),
        .i_center_row  (r_center_row),
        .o_push        (w_push),
        .o_entry       (w_push_data)
    );

    dtpb_queue #(
        .DATA_BITS (ENTRY_BITS),
        .DEPTH     (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_data  (w_q_data),
        .i_pop   (w_q_pop)
    );

    dtpb_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_data    (w_q_data),
        .o_q_pop     (w_q_pop),
        .i_inv_focal (r_inv_focal),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_point_x   (o_point_x),
        .o_point_y   (o_point_y),
        .o_point_z   (o_point_z),
        .o_red_out   (o_red_out),
        .o_green_out (o_green_out),
        .o_blue_out  (o_blue_out)
    );

endmodule
